// File: hw/rtl/dle_pkg.sv
// ----------------------------------------------------------------------------
// dle_pkg: shared types and constants for the DVB locator id extractor
// Prefix table, hex digit decode, parser state and result types.
// ----------------------------------------------------------------------------
package dle_pkg;

  localparam int unsigned PrefixLen = 6;
  localparam int unsigned PosW      = $clog2(PrefixLen + 1);
  localparam logic [7:0]  DotChar   = 8'h2E;
  localparam int unsigned IdW       = 16;

  typedef struct packed {
    logic [PosW-1:0] byte_position;
    logic            prefix_match;
    logic [IdW-1:0]  first_acc;
    logic            first_done;
    logic            dot_seen;
    logic [IdW-1:0]  second_acc;
    logic            second_done;
    logic [IdW-1:0]  tail_acc;
  } dle_state_t;

  localparam dle_state_t StateReset = '{
    byte_position: '0,
    prefix_match:  1'b1,
    first_acc:     '0,
    first_done:    1'b0,
    dot_seen:      1'b0,
    second_acc:    '0,
    second_done:   1'b0,
    tail_acc:      '0
  };

  typedef struct packed {
    logic           prefix_ok;
    logic [IdW-1:0] orig_net_id;
    logic [IdW-1:0] ts_id;
    logic [IdW-1:0] svc_id;
  } dle_ids_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } dle_hex_t;

  // Expected byte of "dvb://" at a given position
  function automatic logic [7:0] prefix_byte(logic [PosW-1:0] pos);
    logic [7:0] b;
    case (pos)
      PosW'(0): b = 8'h64;  // d
      PosW'(1): b = 8'h76;  // v
      PosW'(2): b = 8'h62;  // b
      PosW'(3): b = 8'h3A;  // :
      PosW'(4): b = 8'h2F;  // /
      PosW'(5): b = 8'h2F;  // /
      default:  b = 8'h00;
    endcase
    return b;
  endfunction

  // 0-9, a-f, A-F only
  function automatic dle_hex_t hex_decode(logic [7:0] c);
    dle_hex_t   h;
    logic [7:0] diff;
    h.ok  = 1'b0;
    h.val = 4'h0;
    diff  = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff  = c - 8'h30;
      h.ok  = 1'b1;
      h.val = diff[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff  = c - 8'h57;
      h.ok  = 1'b1;
      h.val = diff[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff  = c - 8'h37;
      h.ok  = 1'b1;
      h.val = diff[3:0];
    end
    return h;
  endfunction

  function automatic logic [IdW-1:0] push_digit(logic [IdW-1:0] acc, logic [3:0] d);
    return {acc[IdW-5:0], d};
  endfunction

endpackage

// File: hw/rtl/dle_char_if.sv
// ----------------------------------------------------------------------------
// dle_char_if: locator byte stream channel
// One string byte per transfer, with a last-byte marker.
// ----------------------------------------------------------------------------
interface dle_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

// File: hw/rtl/dle_ids_if.sv
// ----------------------------------------------------------------------------
// dle_ids_if: extracted identifier channel
// One transfer per string: prefix flag and three 16-bit ids.
// ----------------------------------------------------------------------------
interface dle_ids_if;
  logic        valid;
  logic        ready;
  logic        prefix_ok;
  logic [15:0] orig_net_id;
  logic [15:0] ts_id;
  logic [15:0] svc_id;

  modport source (output valid, output prefix_ok, output orig_net_id,
                  output ts_id, output svc_id, input ready);
  modport sink   (input valid, input prefix_ok, input orig_net_id,
                  input ts_id, input svc_id, output ready);
endinterface

// File: hw/rtl/dle_step.sv
// ----------------------------------------------------------------------------
// dle_step: per-byte parser update
// Next parser state and the result for one locator byte.
// ----------------------------------------------------------------------------
module dle_step (
  input  dle_pkg::dle_state_t state_i,
  input  logic [7:0]          char_byte_i,
  input  logic                is_last_i,
  output dle_pkg::dle_state_t state_o,
  output dle_pkg::dle_ids_t   result_o
);
  import dle_pkg::*;

  dle_hex_t   hex;
  dle_state_t upd;

  assign hex = hex_decode(char_byte_i);

  always_comb begin
    upd = state_i;
    if (state_i.byte_position < PosW'(PrefixLen)) begin
      if (char_byte_i != prefix_byte(state_i.byte_position)) begin
        upd.prefix_match = 1'b0;
      end
      upd.byte_position = state_i.byte_position + PosW'(1);
    end else begin
      if (!state_i.first_done) begin
        if (hex.ok) begin
          upd.first_acc = push_digit(state_i.first_acc, hex.val);
        end else begin
          upd.first_done = 1'b1;
        end
      end
      if (state_i.dot_seen) begin
        if (!state_i.second_done) begin
          if (hex.ok) begin
            upd.second_acc = push_digit(state_i.second_acc, hex.val);
          end else begin
            upd.second_done = 1'b1;
          end
        end
      end else if (char_byte_i == DotChar) begin
        upd.dot_seen = 1'b1;
      end
      upd.tail_acc = hex.ok ? push_digit(state_i.tail_acc, hex.val) : '0;
    end
  end

  always_comb begin
    if (upd.prefix_match && upd.byte_position >= PosW'(PrefixLen)) begin
      result_o.prefix_ok   = 1'b1;
      result_o.orig_net_id = upd.first_acc;
      result_o.ts_id       = upd.dot_seen ? upd.second_acc : '0;
      result_o.svc_id      = upd.tail_acc;
    end else begin
      result_o = '0;
    end
  end

  // The last byte of a string rearms the parser for the next one
  assign state_o = is_last_i ? StateReset : upd;

endmodule

// File: hw/rtl/dvb_locator_id_extractor_core.sv
// ----------------------------------------------------------------------------
// dvb_locator_id_extractor_core: DVB service locator id extractor
// Checks the dvb:// prefix and pulls out three hex ids per string.
// ----------------------------------------------------------------------------
// Feed a locator string one byte per transfer on char_i, with is_last set on
// its final byte. Each byte lands in an input register; from there a short
// update stage folds it into the parser state, and on the last byte the ids
// go to an output register. One byte per cycle is sustained while no last
// byte waits on a stalled result; a string's result reaches ids_o through the input and output registers.
// Bytes keep flowing while a result waits on ids_o, until the next last byte
// needs the output register. Non-last bytes emit nothing. prefix_ok = 0
// (string shorter than six bytes or not "dvb://") comes with all ids zero;
// ts_id is zero when no dot follows the prefix. Every id keeps its low 16
// bits.
// ----------------------------------------------------------------------------
module dvb_locator_id_extractor_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  dle_char_if.sink  char_i,
  dle_ids_if.source ids_o
);
  import dle_pkg::*;

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Parser state
  dle_state_t state_q, state_d;

  // Result register
  logic     out_valid_q;
  dle_ids_t out_q;
  dle_ids_t result;

  logic out_free;
  logic stage_fire;
  logic in_fire;

  // A non-last byte never needs the output register, so it can advance
  // even while a result is stalled.
  assign out_free   = !out_valid_q || ids_o.ready;
  assign stage_fire = in_valid_q && (!in_last_q || out_free);
  assign char_i.ready = !in_valid_q || stage_fire;
  assign in_fire    = char_i.valid && char_i.ready;

  dle_step u_step (
    .state_i     (state_q),
    .char_byte_i (in_byte_q),
    .is_last_i   (in_last_q),
    .state_o     (state_d),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= char_i.char_byte;
      in_last_q <= char_i.is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (stage_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (ids_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_fire && in_last_q) begin
      out_q <= result;
    end
  end

  assign ids_o.valid       = out_valid_q;
  assign ids_o.prefix_ok   = out_q.prefix_ok;
  assign ids_o.orig_net_id = out_q.orig_net_id;
  assign ids_o.ts_id       = out_q.ts_id;
  assign ids_o.svc_id      = out_q.svc_id;

  // Assertions
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_fire && in_last_q |=> state_q == StateReset)
    else $error("parser not rearmed after last byte");

  a_bad_prefix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.prefix_ok |->
      out_q.orig_net_id == '0 && out_q.ts_id == '0 && out_q.svc_id == '0)
    else $error("ids nonzero with bad prefix");

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.byte_position <= PosW'(PrefixLen))
    else $error("byte position past prefix length");

  a_no_dot_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.dot_seen |-> state_q.second_acc == '0 && !state_q.second_done)
    else $error("second id active before dot");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !ids_o.ready |=> out_valid_q && $stable(out_q))
    else $error("stalled result lost");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: DVB locator id extractor check
// Streams locator strings byte by byte into the core and checks every ids
// transfer against a predictor that parses the same bytes. Directed strings
// hit the short, prefix-only and mixed-case cases. Random strings follow:
// mostly well-formed locators with random runs, some short or corrupted
// ones, and raw noise. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

// "dvb://", first character in the top byte
localparam logic [47:0] LocatorPrefix = "dvb://";

// Value of a hex digit, or -1 for any other byte
function automatic int locator_hex_digit(logic [7:0] c);
  if (c >= "0" && c <= "9") return int'(c - "0");
  if (c >= "a" && c <= "f") return int'(c - "a") + 10;
  if (c >= "A" && c <= "F") return int'(c - "A") + 10;
  return -1;
endfunction

class locator_scoreboard;
  dle_pkg::dle_ids_t pending_ids[$];
  int unsigned errors;
  int unsigned bytes_taken;
  int unsigned strings_taken;
  int unsigned good_strings;

  // parser state of the string in flight
  int unsigned n_seen;
  bit          head_ok;
  bit          onid_closed;
  bit          dot_found;
  bit          tsid_closed;
  logic [15:0] onid_acc;
  logic [15:0] tsid_acc;
  logic [15:0] svc_acc;

  function new();
    errors        = 0;
    bytes_taken   = 0;
    strings_taken = 0;
    good_strings  = 0;
    restart();
  endfunction

  function void restart();
    n_seen      = 0;
    head_ok     = 1'b1;
    onid_closed = 1'b0;
    dot_found   = 1'b0;
    tsid_closed = 1'b0;
    onid_acc    = '0;
    tsid_acc    = '0;
    svc_acc     = '0;
  endfunction

  // Fold one accepted byte into the state; a last byte queues its ids
  function void note_byte(logic [7:0] c, logic last);
    int                digit;
    dle_pkg::dle_ids_t ids;
    bytes_taken++;
    if (n_seen < dle_pkg::PrefixLen) begin
      if (c != LocatorPrefix[47 - 8 * n_seen -: 8]) head_ok = 1'b0;
      n_seen++;
    end else begin
      digit = locator_hex_digit(c);
      if (!onid_closed) begin
        if (digit >= 0) onid_acc = {onid_acc[11:0], 4'(digit)};
        else onid_closed = 1'b1;
      end
      if (dot_found) begin
        if (!tsid_closed) begin
          if (digit >= 0) tsid_acc = {tsid_acc[11:0], 4'(digit)};
          else tsid_closed = 1'b1;
        end
      end else if (c == dle_pkg::DotChar) begin
        dot_found = 1'b1;
      end
      svc_acc = (digit >= 0) ? {svc_acc[11:0], 4'(digit)} : 16'h0000;
    end
    if (last) begin
      ids = '0;
      if (head_ok && n_seen >= dle_pkg::PrefixLen) begin
        ids.prefix_ok   = 1'b1;
        ids.orig_net_id = onid_acc;
        ids.ts_id       = dot_found ? tsid_acc : 16'h0000;
        ids.svc_id      = svc_acc;
        good_strings++;
      end
      pending_ids.push_back(ids);
      strings_taken++;
      restart();
    end
  endfunction

  task report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task check_ids(dle_pkg::dle_ids_t got);
    dle_pkg::dle_ids_t want;
    if (pending_ids.size() == 0) begin
      report_mismatch($sformatf("ids transfer with none expected: %p", got));
    end else begin
      want = pending_ids.pop_front();
      if (got.prefix_ok !== want.prefix_ok)
        report_mismatch($sformatf("prefix_ok %b, want %b", got.prefix_ok, want.prefix_ok));
      if (got.orig_net_id !== want.orig_net_id)
        report_mismatch($sformatf("orig_net_id %h, want %h",
                                  got.orig_net_id, want.orig_net_id));
      if (got.ts_id !== want.ts_id)
        report_mismatch($sformatf("ts_id %h, want %h", got.ts_id, want.ts_id));
      if (got.svc_id !== want.svc_id)
        report_mismatch($sformatf("svc_id %h, want %h", got.svc_id, want.svc_id));
    end
  endtask
endclass

module testbench;

  logic clk_i;
  logic rst_ni;

  dle_char_if char_ch ();
  dle_ids_if  ids_ch ();

  dvb_locator_id_extractor_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_ch),
    .ids_o  (ids_ch)
  );

  locator_scoreboard sb = new();

  // string being built, sent byte by byte by send_text
  logic [7:0] text_q[$];
  // source runs back to back while set; toggled now and then per string
  bit src_quiet = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("run timed out");
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [7:0] hex_char();
    int unsigned k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'("0" + k);
    if (k < 16) return 8'("a" + k - 10);
    return 8'("A" + k - 16);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom); while (locator_hex_digit(c) >= 0);
    return c;
  endfunction

  // Mostly short runs; now and then one long enough to overflow 16 bits
  function automatic int unsigned run_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
  endfunction

  function automatic void push_hex_run(int unsigned n);
    repeat (n) text_q.push_back(hex_char());
  endfunction

  function automatic void push_str(string s);
    foreach (s[i]) text_q.push_back(s[i]);
  endfunction

  // Send text_q as one string: is_last on the final byte. Unless src_quiet is
  // set, each byte may first wait a random idle gap, with noise on the data lines while idle.
  task automatic send_text();
    int unsigned gap;
    bit          last;
    if ($urandom_range(0, 7) == 0) src_quiet = !src_quiet;
    foreach (text_q[i]) begin
      last = (i == text_q.size() - 1);
      gap  = src_quiet ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
        @(negedge clk_i);
        char_ch.valid     <= 1'b0;
        char_ch.char_byte <= 8'($urandom);
        char_ch.is_last   <= 1'($urandom);
      end
      @(negedge clk_i);
      char_ch.valid     <= 1'b1;
      char_ch.char_byte <= text_q[i];
      char_ch.is_last   <= last;
      do @(posedge clk_i); while (char_ch.ready !== 1'b1);
      sb.note_byte(text_q[i], last);
    end
    text_q.delete();
  endtask

  // One random string into text_q
  task automatic build_random_locator();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // well-formed shape: prefix, first run, optional dot or separator, junk, tail
      push_str("dvb://");
      if ($urandom_range(0, 9) == 0) text_q[$urandom_range(0, 5)] = 8'($urandom);
      push_hex_run(run_len());
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          text_q.push_back(dle_pkg::DotChar);
          push_hex_run(run_len());
        end
        6, 7, 8: text_q.push_back(non_hex_char());
        default: ;
      endcase
      repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom));
      if ($urandom_range(0, 3) != 0) text_q.push_back(non_hex_char());
      push_hex_run(run_len());
    end else if (kind < 82) begin
      // too short: a leading piece of the prefix, sometimes spoiled
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) text_q.push_back(LocatorPrefix[47 - 8 * i -: 8]);
      if ($urandom_range(0, 2) == 0) text_q[n - 1] = 8'($urandom);
    end else begin
      // raw noise
      n = $urandom_range(1, 14);
      repeat (n) text_q.push_back(8'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Ids sink: random stall before each transfer unless in quiet mode, checked at the
  // rising edge where valid and ready meet.
  // --------------------------------------------------------------------------
  initial begin : ids_sink
    int unsigned       stall;
    bit                quiet;
    dle_pkg::dle_ids_t got;
    quiet        = 1'b0;
    ids_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      stall = quiet ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        @(negedge clk_i);
        ids_ch.ready <= 1'b0;
      end
      @(negedge clk_i);
      ids_ch.ready <= 1'b1;
      do @(posedge clk_i); while (ids_ch.valid !== 1'b1);
      got.prefix_ok   = ids_ch.prefix_ok;
      got.orig_net_id = ids_ch.orig_net_id;
      got.ts_id       = ids_ch.ts_id;
      got.svc_id      = ids_ch.svc_id;
      sb.check_ids(got);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni            = 1'b0;
    char_ch.valid     = 1'b0;
    char_ch.char_byte = 8'h00;
    char_ch.is_last   = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single high byte (short string)
    text_q.push_back(8'hFF);
    send_text();
    // prefix cut one byte short
    push_str("dvb:/");
    send_text();
    // exact prefix: empty runs, no dot
    push_str("dvb://");
    send_text();
    // mixed-case first id, dot, second id ended by a high byte, one-digit tail
    push_str("dvb://fA9.0");
    text_q.push_back(8'h80);
    push_str("c");
    send_text();

    // Random strings
    while (sb.bytes_taken < 400 || sb.strings_taken < 24) begin
      build_random_locator();
      send_text();
    end

    @(negedge clk_i);
    char_ch.valid <= 1'b0;

    // Drain: every expected ids transfer, then wait for strays
    while (sb.pending_ids.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("streamed %0d bytes as %0d locator strings, %0d with a valid prefix",
             sb.bytes_taken, sb.strings_taken, sb.good_strings);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
